@@ hdl/bbcd_pkg.sv @@
// Package: shared types, constants and helpers for the binary to BCD digit mux.
`default_nettype none

package bbcd_pkg;

	localparam int DISPLAY_DIGITS = 3;
	localparam logic [1:0] DIGITS_RESET = 2'd3;

	// Residues of powers of two modulo one thousand.
	localparam int RES_2P10 = 24;
	localparam int RES_2P20 = 576;

	typedef struct packed {
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] units;
	} bbcd_digits_t;

	function automatic logic [1:0] eff_count(input logic [1:0] d);
		logic [1:0] n;
		n = d;
		if (n == 2'd0) begin
			n = 2'd1;
		end
		if (int'(n) > DISPLAY_DIGITS) begin
			n = 2'(DISPLAY_DIGITS);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ hdl/bbcd_value_if.sv @@
// Interface: input value channel.
`default_nettype none

interface bbcd_value_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/bbcd_digit_if.sv @@
// Interface: digit result channel.
`default_nettype none

interface bbcd_digit_if;
	logic       valid;
	logic       ready;
	logic [1:0] digit_position;
	logic [3:0] bcd_digit;
	logic       last_digit;

	modport source(output valid, output digit_position, output bcd_digit, output last_digit,
		input ready);
	modport sink(input valid, input digit_position, input bcd_digit, input last_digit,
		output ready);
endinterface

`default_nettype wire

@@ hdl/bbcd_mod_pipe.sv @@
// Pipeline: value modulo 1000 by residue folding, then split into three BCD digits.
`default_nettype none

module bbcd_mod_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	bbcd_value_if.sink            number,
	output logic                  dig_valid,
	input  logic                  dig_ready,
	output bbcd_pkg::bbcd_digits_t dig
);

	localparam int NSTG = 8;

	logic [NSTG:1] stage_vld_q;
	logic [NSTG:1] en;

	logic [21:0] x_s1;
	logic [15:0] x_s2;
	logic [11:0] x_s3;
	logic [9:0]  r_s4;
	logic [9:0]  r_s5;
	logic [3:0]  h_s5;
	logic [6:0]  m_s6;
	logic [3:0]  h_s6;
	logic [6:0]  m_s7;
	logic [3:0]  t_s7;
	logic [3:0]  h_s7;
	logic [3:0]  u_s8;
	logic [3:0]  t_s8;
	logic [3:0]  h_s8;

	logic [10:0] m_diff;
	logic [6:0]  u_diff;

	assign en[NSTG] = !stage_vld_q[NSTG] || dig_ready;
	for (genvar k = 1; k < NSTG; k++) begin : g_en
		assign en[k] = !stage_vld_q[k] || en[k + 1];
	end

	assign number.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[1]) begin
				stage_vld_q[1] <= number.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k - 1];
				end
			end
		end
	end

	assign m_diff = 11'(r_s5) - 11'(h_s5) * 11'd100;
	assign u_diff = m_s7 - 7'(t_s7) * 7'd10;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1 <= 22'(number.value[31:20]) * 22'(bbcd_pkg::RES_2P20)
				+ 22'(number.value[19:10]) * 22'(bbcd_pkg::RES_2P10)
				+ 22'(number.value[9:0]);
		end
		if (en[2]) begin
			x_s2 <= 16'(x_s1[21:10]) * 16'(bbcd_pkg::RES_2P10) + 16'(x_s1[9:0]);
		end
		if (en[3]) begin
			x_s3 <= 12'(x_s2[15:10]) * 12'(bbcd_pkg::RES_2P10) + 12'(x_s2[9:0]);
		end
		if (en[4]) begin
			if (x_s3 >= 12'd2000) begin
				r_s4 <= 10'(x_s3 - 12'd2000);
			end else if (x_s3 >= 12'd1000) begin
				r_s4 <= 10'(x_s3 - 12'd1000);
			end else begin
				r_s4 <= x_s3[9:0];
			end
		end
		if (en[5]) begin
			r_s5 <= r_s4;
			h_s5 <= 4'((16'(r_s4) * 16'd41) >> 12);
		end
		if (en[6]) begin
			m_s6 <= m_diff[6:0];
			h_s6 <= h_s5;
		end
		if (en[7]) begin
			m_s7 <= m_s6;
			t_s7 <= 4'((14'(m_s6) * 14'd103) >> 10);
			h_s7 <= h_s6;
		end
		if (en[8]) begin
			u_s8 <= u_diff[3:0];
			t_s8 <= t_s7;
			h_s8 <= h_s7;
		end
	end

	assign dig_valid    = stage_vld_q[NSTG];
	assign dig.hundreds = h_s8;
	assign dig.tens     = t_s8;
	assign dig.units    = u_s8;

endmodule

`default_nettype wire

@@ hdl/bbcd_serializer.sv @@
// Serializer: emits the digits in use of each value, most significant first.
`default_nettype none

module bbcd_serializer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             digits_in_use,
	input  logic                   dig_valid,
	output logic                   dig_ready,
	input  bbcd_pkg::bbcd_digits_t dig,
	bbcd_digit_if.source           digits
);

	logic                   busy_q;
	logic [1:0]             pos_q;
	logic [1:0]             cnt_q;
	bbcd_pkg::bbcd_digits_t dig_q;

	logic       last;
	logic       load;
	logic       xfer;
	logic [1:0] idx;

	assign last      = pos_q == (cnt_q - 2'd1);
	assign xfer      = busy_q && digits.ready;
	assign dig_ready = !busy_q || (digits.ready && last);
	assign load      = dig_valid && dig_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			cnt_q  <= 2'd1;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
				cnt_q  <= bbcd_pkg::eff_count(digits_in_use);
			end else if (xfer) begin
				if (last) begin
					busy_q <= 1'b0;
					pos_q  <= '0;
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= dig;
		end
	end

	// idx counts from the least significant digit
	assign idx = cnt_q - 2'd1 - pos_q;

	always_comb begin
		unique case (idx)
			2'd0:    digits.bcd_digit = dig_q.units;
			2'd1:    digits.bcd_digit = dig_q.tens;
			2'd2:    digits.bcd_digit = dig_q.hundreds;
			default: digits.bcd_digit = '0;
		endcase
	end

	assign digits.valid          = busy_q;
	assign digits.digit_position = pos_q;
	assign digits.last_digit     = last;

endmodule

`default_nettype wire

@@ hdl/binary_to_bcd_digit_mux.sv @@
// Top level: binary to BCD converter driving a multiplexed seven-segment display.
// Each accepted 32-bit value is reduced modulo 1000 in an eight-stage pipeline that
// accepts a value every cycle unless back-pressure from the result channel holds it,
// and its low n digits (n = digits_in_use, 0 taken as 1) then leave one per cycle
// while digits.ready is high, most significant first, on digit positions 0..n-1, the
// final one marked by last_digit. Each value takes n digit transfers of the single
// result channel. The user must write digits_in_use through cfg_we/cfg_wdata only
// while no value is in flight (the block does not enforce this); it resets to three.
`default_nettype none

module binary_to_bcd_digit_mux (
	input  logic         clk,
	input  logic         arst_n,
	bbcd_value_if.sink   number,
	bbcd_digit_if.source digits,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_wdata
);

	logic [1:0]             digits_in_use_q;
	logic                   dig_valid;
	logic                   dig_ready;
	bbcd_pkg::bbcd_digits_t dig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_in_use_q <= bbcd_pkg::DIGITS_RESET;
		end else if (cfg_we) begin
			digits_in_use_q <= cfg_wdata;
		end
	end

	bbcd_mod_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.number    (number),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	bbcd_serializer u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.digits_in_use (digits_in_use_q),
		.dig_valid     (dig_valid),
		.dig_ready     (dig_ready),
		.dig           (dig),
		.digits        (digits)
	);

endmodule

`default_nettype wire
